/* hdl/y4m_pkg.sv */
`default_nettype none

package y4m_pkg;

    // Field widths
    localparam int BYTE_W  = 8;
    localparam int DIM_W   = 16;
    localparam int ACC_W   = 32;
    localparam int RATE_W  = 16;
    localparam int DIGIT_W = 4;

    // The divider works on numerator + denominator - 1, which needs one extra bit.
    localparam int DIV_W     = ACC_W + 1;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);

    // Header characters
    localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0a;
    localparam logic [BYTE_W-1:0] CH_W       = 8'h57;
    localparam logic [BYTE_W-1:0] CH_H       = 8'h48;
    localparam logic [BYTE_W-1:0] CH_F       = 8'h46;
    localparam logic [BYTE_W-1:0] CH_POINT   = 8'h2e;
    localparam logic [BYTE_W-1:0] CH_COLON   = 8'h3a;
    localparam logic [BYTE_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE    = 8'h39;

    localparam logic [BYTE_W-1:0] DEFAULT_RATE_RST = 8'd30;

    // Handshake between the sequencer and the divider.
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage

`default_nettype wire

/* hdl/y4m_mac.sv */
`default_nettype none

// Shared multiply-by-ten-and-add unit with saturation at 16 or 32 bits.
module y4m_mac (
    input  wire logic [y4m_pkg::ACC_W-1:0]   i_acc,
    input  wire logic [y4m_pkg::DIGIT_W-1:0] i_digit,
    input  wire logic                        i_wide,
    output logic      [y4m_pkg::ACC_W-1:0]   o_result
);
    import y4m_pkg::*;

    localparam int SUM_W = ACC_W + 4;

    logic [SUM_W-1:0] w_sum;
    logic             w_over;

    // acc * 10 is acc * 8 + acc * 2.
    assign w_sum = {1'b0, i_acc, 3'b000} + {3'b000, i_acc, 1'b0}
                 + {{(SUM_W-DIGIT_W){1'b0}}, i_digit};

    // Anything above the active field maximum clamps to it.
    always_comb begin
        if (i_wide) begin
            w_over = |w_sum[SUM_W-1:ACC_W];
        end else begin
            w_over = |w_sum[SUM_W-1:DIM_W];
        end
    end

    always_comb begin
        if (!w_over) begin
            o_result = w_sum[ACC_W-1:0];
        end else if (i_wide) begin
            o_result = {ACC_W{1'b1}};
        end else begin
            o_result = {{(ACC_W-DIM_W){1'b0}}, {DIM_W{1'b1}}};
        end
    end

endmodule

`default_nettype wire

/* hdl/y4m_div.sv */
`default_nettype none

// Restoring divider, one quotient bit per cycle, giving ceil(num / den).
module y4m_div (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [y4m_pkg::ACC_W-1:0] i_num,
    input  wire logic [y4m_pkg::ACC_W-1:0] i_den,
    output y4m_pkg::t_div_status           o_status,
    output logic      [y4m_pkg::DIV_W-1:0] o_quotient
);
    import y4m_pkg::*;

    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_done;
    logic [ACC_W-1:0]     r_rem;
    logic [DIV_W-1:0]     r_quo;
    logic [ACC_W-1:0]     r_den;

    logic [DIV_W-1:0] w_dividend;
    logic [DIV_W-1:0] w_shift;
    logic [DIV_W:0]   w_diff;
    logic             w_ge;

    // Rounding up is done by dividing num + den - 1.
    assign w_dividend = {1'b0, i_num} + {1'b0, i_den} - {{(DIV_W-1){1'b0}}, 1'b1};

    assign w_shift = {r_rem, r_quo[DIV_W-1]};
    assign w_diff  = {1'b0, w_shift} - {2'b00, r_den};
    assign w_ge    = !w_diff[DIV_W];

    // Iteration counter and completion pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == DIV_CNT_W'(1));
            if (i_start) begin
                r_cnt <= DIV_CNT_W'(DIV_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - DIV_CNT_W'(1);
            end
        end
    end

    // Remainder and quotient shift registers.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= w_dividend;
            r_den <= i_den;
        end else if (r_cnt != '0) begin
            r_rem <= w_ge ? w_diff[ACC_W-1:0] : w_shift[ACC_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], w_ge};
        end
    end

    assign o_status.busy = (r_cnt != '0);
    assign o_status.done = r_done;
    assign o_quotient    = r_quo;

endmodule

`default_nettype wire

/* hdl/y4m_header_parser.sv */
// A space or non-digit byte is handled in the idle state; a digit passes once through the
// multiply-add state, and a fraction digit passes through it twice, for the numerator and then
// the denominator. A newline goes through the prepare and emit states to the output register;
// with a rate token the 33-step divider runs between them. The input takes one byte at a time
// and is held off until the parser is idle again. Reset (synchronous, active low) clears the
// parser and output valid and restores the default frame rate register to 30.
`default_nettype none

module y4m_header_parser (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // Configuration
    input  wire logic                         i_cfg_wr_en,
    input  wire logic [y4m_pkg::BYTE_W-1:0]   i_cfg_wr_data,
    // Header byte input
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic [y4m_pkg::BYTE_W-1:0]   i_header_byte,
    // Result output
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic      [y4m_pkg::DIM_W-1:0]    o_frame_width,
    output logic      [y4m_pkg::DIM_W-1:0]    o_frame_height,
    output logic      [y4m_pkg::ACC_W-1:0]    o_rate_numerator,
    output logic      [y4m_pkg::ACC_W-1:0]    o_rate_denominator,
    output logic      [y4m_pkg::RATE_W-1:0]   o_frame_rate,
    output logic                              o_format_error,
    output logic                              o_zero_denominator
);
    import y4m_pkg::*;

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MAC  = 3'd1;
    localparam logic [2:0] S_PREP = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    // Parse phases
    localparam logic [2:0] PH_SKIP_FIRST = 3'd0;
    localparam logic [2:0] PH_EXPECT_ID  = 3'd1;
    localparam logic [2:0] PH_WIDTH      = 3'd2;
    localparam logic [2:0] PH_HEIGHT     = 3'd3;
    localparam logic [2:0] PH_RATE_INT   = 3'd4;
    localparam logic [2:0] PH_RATE_FRAC  = 3'd5;
    localparam logic [2:0] PH_RATE_DEN   = 3'd6;
    localparam logic [2:0] PH_SKIP_TOKEN = 3'd7;

    // Accumulator selected for the multiply-add unit
    localparam logic [1:0] OP_WIDTH  = 2'd0;
    localparam logic [1:0] OP_HEIGHT = 2'd1;
    localparam logic [1:0] OP_NUMER  = 2'd2;
    localparam logic [1:0] OP_DENOM  = 2'd3;

    logic [2:0]         r_state, n_state;
    logic [2:0]         r_phase, n_phase;
    logic [DIM_W-1:0]   r_width, n_width;
    logic [DIM_W-1:0]   r_height, n_height;
    logic [ACC_W-1:0]   r_numer, n_numer;
    logic [ACC_W-1:0]   r_denom, n_denom;
    logic               r_rate_seen, n_rate_seen;
    logic               r_error, n_error;
    logic [1:0]         r_op, n_op;
    logic [DIGIT_W-1:0] r_digit, n_digit;
    logic               r_frac, n_frac;
    logic [RATE_W-1:0]  r_rate, n_rate;
    logic               r_zden, n_zden;
    logic [BYTE_W-1:0]  r_default;

    logic               w_in_acc;
    logic               w_out_free;
    logic               w_emit;
    logic               w_is_digit;
    logic [DIGIT_W-1:0] w_byte_digit;
    logic [ACC_W-1:0]   w_mac_acc;
    logic               w_mac_wide;
    logic [ACC_W-1:0]   w_mac_res;
    logic               w_div_start;
    t_div_status        w_div_status;
    logic [DIV_W-1:0]   w_quotient;

    assign o_in_stall   = (r_state != S_IDLE);
    assign w_in_acc     = i_in_valid && !o_in_stall;
    assign w_out_free   = !o_out_valid || !i_out_stall;
    assign w_emit       = (r_state == S_EMIT) && w_out_free;
    assign w_is_digit   = (i_header_byte >= CH_ZERO) && (i_header_byte <= CH_NINE);
    assign w_byte_digit = i_header_byte[DIGIT_W-1:0];

    // Shared multiply-add unit, fed from the selected accumulator.
    always_comb begin
        unique case (r_op)
            OP_WIDTH: begin
                w_mac_acc  = {{(ACC_W-DIM_W){1'b0}}, r_width};
                w_mac_wide = 1'b0;
            end
            OP_HEIGHT: begin
                w_mac_acc  = {{(ACC_W-DIM_W){1'b0}}, r_height};
                w_mac_wide = 1'b0;
            end
            OP_NUMER: begin
                w_mac_acc  = r_numer;
                w_mac_wide = 1'b1;
            end
            OP_DENOM: begin
                w_mac_acc  = r_denom;
                w_mac_wide = 1'b1;
            end
            default: begin
                w_mac_acc  = r_numer;
                w_mac_wide = 1'b1;
            end
        endcase
    end

    y4m_mac u_mac (
        .i_acc    (w_mac_acc),
        .i_digit  (r_digit),
        .i_wide   (w_mac_wide),
        .o_result (w_mac_res)
    );

    y4m_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_num      (r_numer),
        .i_den      (r_denom),
        .o_status   (w_div_status),
        .o_quotient (w_quotient)
    );

    // Sequencer and parser next-state logic.
    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_width     = r_width;
        n_height    = r_height;
        n_numer     = r_numer;
        n_denom     = r_denom;
        n_rate_seen = r_rate_seen;
        n_error     = r_error;
        n_op        = r_op;
        n_digit     = r_digit;
        n_frac      = r_frac;
        n_rate      = r_rate;
        n_zden      = r_zden;
        w_div_start = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_digit = w_byte_digit;
                    n_frac  = 1'b0;
                    if (i_header_byte == CH_NEWLINE) begin
                        n_state = S_PREP;
                    end else begin
                        unique case (r_phase)
                            PH_SKIP_FIRST, PH_SKIP_TOKEN: begin
                                if (i_header_byte == CH_SPACE) begin
                                    n_phase = PH_EXPECT_ID;
                                end
                            end
                            PH_EXPECT_ID: begin
                                if (i_header_byte == CH_SPACE) begin
                                    n_phase = PH_EXPECT_ID;
                                end else if (i_header_byte == CH_W) begin
                                    n_width = '0;
                                    n_phase = PH_WIDTH;
                                end else if (i_header_byte == CH_H) begin
                                    n_height = '0;
                                    n_phase  = PH_HEIGHT;
                                end else if (i_header_byte == CH_F) begin
                                    n_numer     = '0;
                                    n_denom     = ACC_W'(1);
                                    n_rate_seen = 1'b1;
                                    n_phase     = PH_RATE_INT;
                                end else begin
                                    n_phase = PH_SKIP_TOKEN;
                                end
                            end
                            PH_WIDTH, PH_HEIGHT: begin
                                if (i_header_byte == CH_SPACE) begin
                                    n_phase = PH_EXPECT_ID;
                                end else if (!w_is_digit) begin
                                    n_error = 1'b1;
                                end else begin
                                    n_op    = (r_phase == PH_WIDTH) ? OP_WIDTH : OP_HEIGHT;
                                    n_state = S_MAC;
                                end
                            end
                            PH_RATE_INT: begin
                                if (i_header_byte == CH_SPACE) begin
                                    n_phase = PH_EXPECT_ID;
                                end else if (i_header_byte == CH_POINT) begin
                                    n_phase = PH_RATE_FRAC;
                                end else if (i_header_byte == CH_COLON) begin
                                    n_denom = '0;
                                    n_phase = PH_RATE_DEN;
                                end else if (!w_is_digit) begin
                                    n_error = 1'b1;
                                end else begin
                                    n_op    = OP_NUMER;
                                    n_state = S_MAC;
                                end
                            end
                            PH_RATE_FRAC: begin
                                if (i_header_byte == CH_SPACE) begin
                                    n_phase = PH_EXPECT_ID;
                                end else if (!w_is_digit) begin
                                    n_error = 1'b1;
                                end else begin
                                    n_op    = OP_NUMER;
                                    n_frac  = 1'b1;
                                    n_state = S_MAC;
                                end
                            end
                            PH_RATE_DEN: begin
                                if (i_header_byte == CH_SPACE) begin
                                    n_phase = PH_EXPECT_ID;
                                end else if (!w_is_digit) begin
                                    n_error = 1'b1;
                                end else begin
                                    n_op    = OP_DENOM;
                                    n_state = S_MAC;
                                end
                            end
                            default: begin
                                n_phase = PH_SKIP_TOKEN;
                            end
                        endcase
                    end
                end
            end
            S_MAC: begin
                unique case (r_op)
                    OP_WIDTH:  n_width  = w_mac_res[DIM_W-1:0];
                    OP_HEIGHT: n_height = w_mac_res[DIM_W-1:0];
                    OP_NUMER:  n_numer  = w_mac_res;
                    OP_DENOM:  n_denom  = w_mac_res;
                    default:   n_numer  = w_mac_res;
                endcase
                // A fraction digit also scales the denominator by ten.
                if (r_frac) begin
                    n_op    = OP_DENOM;
                    n_digit = '0;
                    n_frac  = 1'b0;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_PREP: begin
                n_zden = 1'b0;
                if (!r_rate_seen) begin
                    n_rate  = {{(RATE_W-BYTE_W){1'b0}}, r_default};
                    n_state = S_EMIT;
                end else if (r_denom == '0) begin
                    n_rate  = '0;
                    n_zden  = 1'b1;
                    n_state = S_EMIT;
                end else begin
                    w_div_start = 1'b1;
                    n_state     = S_DIV;
                end
            end
            S_DIV: begin
                if (w_div_status.done) begin
                    if (|w_quotient[DIV_W-1:RATE_W]) begin
                        n_rate = {RATE_W{1'b1}};
                    end else begin
                        n_rate = w_quotient[RATE_W-1:0];
                    end
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                // The header is done: return the parser to its reset state.
                if (w_out_free) begin
                    n_phase     = PH_SKIP_FIRST;
                    n_width     = '0;
                    n_height    = '0;
                    n_numer     = '0;
                    n_denom     = '0;
                    n_rate_seen = 1'b0;
                    n_error     = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control and accumulator registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_SKIP_FIRST;
            r_width     <= '0;
            r_height    <= '0;
            r_numer     <= '0;
            r_denom     <= '0;
            r_rate_seen <= 1'b0;
            r_error     <= 1'b0;
            r_frac      <= 1'b0;
            r_zden      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_width     <= n_width;
            r_height    <= n_height;
            r_numer     <= n_numer;
            r_denom     <= n_denom;
            r_rate_seen <= n_rate_seen;
            r_error     <= n_error;
            r_frac      <= n_frac;
            r_zden      <= n_zden;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_digit <= n_digit;
        r_rate  <= n_rate;
    end

    // Default frame rate register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default <= DEFAULT_RATE_RST;
        end else if (i_cfg_wr_en) begin
            r_default <= i_cfg_wr_data;
        end
    end

    // Output register; it is loaded only when empty or being drained.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (w_emit) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            o_frame_width      <= r_width;
            o_frame_height     <= r_height;
            o_rate_numerator   <= r_rate_seen ? r_numer
                                              : {{(ACC_W-BYTE_W){1'b0}}, r_default};
            o_rate_denominator <= r_rate_seen ? r_denom : ACC_W'(1);
            o_frame_rate       <= r_rate;
            o_format_error     <= r_error;
            o_zero_denominator <= r_zden;
        end
    end

endmodule

`default_nettype wire

/* hdl/y4m_header_parser_chk.sv */
`default_nettype none

module y4m_header_parser_chk (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_in_valid,
    input wire logic                         o_in_stall,
    input wire logic [y4m_pkg::BYTE_W-1:0]   i_header_byte,
    input wire logic                         o_out_valid,
    input wire logic                         i_out_stall,
    input wire logic [y4m_pkg::DIM_W-1:0]    o_frame_width,
    input wire logic [y4m_pkg::ACC_W-1:0]    o_rate_denominator,
    input wire logic [y4m_pkg::RATE_W-1:0]   o_frame_rate,
    input wire logic                         o_zero_denominator
);

    // A held result keeps its beat.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_frame_width)
            && $stable(o_frame_rate))
        else $error("stalled result changed");

    // A newline ends the header, so the input is held off while the result is formed.
    a_newline_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_header_byte == y4m_pkg::CH_NEWLINE) |=> o_in_stall)
        else $error("input taken right after a newline");

    // A zero denominator flag goes together with a zero denominator and rate.
    a_zden_rate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_zero_denominator |-> (o_frame_rate == '0)
            && (o_rate_denominator == '0))
        else $error("zero denominator flag with nonzero rate");

    // A zero denominator is always flagged.
    a_den_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_rate_denominator == '0) |-> o_zero_denominator)
        else $error("zero denominator not flagged");

    // Reset empties the output register.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind y4m_header_parser y4m_header_parser_chk u_y4m_chk (.*);

`default_nettype wire
